// ===== hdl/mwfid_pkg.sv =====
// Shared types and constants for the mapped word memory with flash ID emulation.
`default_nettype none

package mwfid_pkg;

    localparam int ADDR_W        = 32;
    localparam int DATA_W        = 32;
    localparam int LEN_W         = 17;
    localparam int PHYS_W        = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int REM_STEP_BITS = 4;

    typedef enum logic [1:0] {
        OP_RD_WORD = 2'd0,
        OP_WR_WORD = 2'd1,
        OP_RD_BYTE = 2'd2,
        OP_WR_BYTE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        FL_IDLE     = 3'd0,
        FL_STEP1    = 3'd1,
        FL_STEP2    = 3'd2,
        FL_STEP3    = 3'd3,
        FL_UNLOCKED = 3'd4,
        FL_FAILED   = 3'd7
    } t_flash;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_REM1,
        ST_IDX,
        ST_ACCESS,
        ST_RESP
    } t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_ADDR     = 3'd0,
        REG_REGION_LENGTH = 3'd1,
        REG_ALIAS_BASE    = 3'd2,
        REG_ALIAS_PHYS    = 3'd3,
        REG_ALIAS_LENGTH  = 3'd4,
        REG_FLASH_CODE    = 3'd5,
        REG_READ_ONLY     = 3'd6
    } t_reg;

    localparam logic [LEN_W-1:0]  REGION_LEN_RESET = 17'h10000;

    localparam logic [DATA_W-1:0] FL_RESET_WORD   = 32'hf0f0f0f0;
    localparam logic [DATA_W-1:0] FL_UNLOCK1_WORD = 32'haaaaaaaa;
    localparam logic [DATA_W-1:0] FL_UNLOCK2_WORD = 32'h55555555;
    localparam logic [DATA_W-1:0] FL_AUTOSEL_WORD = 32'h90909090;
    localparam logic [15:0]       FL_ADDR_A       = 16'h5550;
    localparam logic [15:0]       FL_ADDR_B       = 16'haaa0;
    localparam logic [ADDR_W-1:0] FL_ID_ADDR      = 32'd4;

endpackage

`default_nettype wire

// ===== hdl/mapped_word_memory_flash_id_top.sv =====
// Top level: mapped big-endian word memory with byte lanes and flash ID emulation.
//
// Usage: raise start with i_op, i_address and i_write_data while busy is low;
// the command is taken at that clock edge and busy rises. One result comes back
// as o_data / o_write_blocked with o_valid high for exactly one cycle; the
// receiver cannot stall it. busy drops in the cycle o_valid is high, so the
// next command can be taken at the edge that ends the result cycle.
// The address maps directly when it hits the alias window, already lies inside the
// main region or region_length is zero; otherwise the offset is first reduced
// modulo region_length in the remainder unit (8 steps of 4 bits).
// The word index is the low bits of the physical word address (STORE_WORDS is
// a power of two). The state sits in one single-port RAM, read in ST_ACCESS
// and written back in ST_RESP.
// Configuration: i_cfg_we / i_cfg_index / i_cfg_data write one register per
// edge, taken at any time; write only while no command is in flight.
// Reset: synchronous, active low. Afterwards the store is cleared one word a
// cycle, all STORE_WORDS words, with busy high; registers return to defaults.
`default_nettype none

module mapped_word_memory_flash_id_top
    import mwfid_pkg::*;
#(
    parameter int STORE_WORDS = 16384
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_op,
    input  wire logic [ADDR_W-1:0]    i_address,
    input  wire logic [DATA_W-1:0]    i_write_data,
    output logic                      o_valid,
    output logic      [DATA_W-1:0]    o_data,
    output logic                      o_write_blocked,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DATA_W-1:0]    i_cfg_data
);

    localparam int IDX_W = $clog2(STORE_WORDS);

    // configuration
    logic [ADDR_W-1:0] r_base_addr;
    logic [LEN_W-1:0]  r_region_length;
    logic [ADDR_W-1:0] r_alias_base;
    logic [PHYS_W-1:0] r_alias_phys;
    logic [LEN_W-1:0]  r_alias_length;
    logic [DATA_W-1:0] r_flash_code;
    logic              r_read_only;

    // control and command
    t_state            r_state, n_state;
    t_flash            r_flash, n_flash;
    t_op               r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_wdata;
    logic [ADDR_W-1:0] r_pa;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_clr;
    logic              r_valid;
    logic [DATA_W-1:0] r_data;
    logic              r_blocked;

    // datapath
    logic              is_byte;
    logic [ADDR_W-1:0] va;
    logic [ADDR_W-1:0] off_alias;
    logic [ADDR_W-1:0] off_main;
    logic              alias_hit;
    logic [ADDR_W-1:0] alias_pa;
    logic              len_zero;
    logic              in_region;
    logic              map_direct;

    logic              rem_start;
    logic              rem_done;
    logic [LEN_W-1:0]  rem_value;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_addr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    logic [1:0]        lane;
    logic [7:0]        rd_byte;
    logic [DATA_W-1:0] merged;
    logic [15:0]       sel;
    logic              consumed;
    logic [DATA_W-1:0] n_data;
    logic              n_blocked;

    // ---------------- address map ----------------
    always_comb begin
        is_byte    = (r_op == OP_RD_BYTE) || (r_op == OP_WR_BYTE);
        va         = is_byte ? {r_addr[ADDR_W-1:2], 2'b00} : r_addr;
        off_alias  = va - r_alias_base;
        alias_hit  = (r_alias_length != '0) && (off_alias < ADDR_W'(r_alias_length));
        alias_pa   = ADDR_W'(LEN_W'(r_alias_phys) + off_alias[LEN_W-1:0]);
        off_main   = va - r_base_addr;
        len_zero   = (r_region_length == '0);
        in_region  = off_main < ADDR_W'(r_region_length);
        map_direct = alias_hit || len_zero || in_region;
    end

    always_comb begin
        rem_start = (r_state == ST_MAP) && !map_direct;
    end

    mwfid_rem #(
        .DIV_W (LEN_W)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (off_main),
        .i_divisor  (r_region_length),
        .o_done     (rem_done),
        .o_rem      (rem_value)
    );

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (r_clr == IDX_W'(STORE_WORDS - 1)) n_state = ST_IDLE;
            ST_IDLE:   if (start) n_state = ST_MAP;
            ST_MAP:    n_state = map_direct ? ST_IDX : ST_REM1;
            ST_REM1:   if (rem_done) n_state = ST_IDX;
            ST_IDX:    n_state = ST_ACCESS;
            ST_ACCESS: n_state = ST_RESP;
            ST_RESP:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // ---------------- response, flash sequencer, write-back ----------------
    always_comb begin
        lane    = r_addr[1:0];
        rd_byte = ram_rdata[{~lane, 3'b000} +: 8];
        for (int k = 0; k < 4; k++) begin
            merged[k*8 +: 8] = (2'(3 - k) == lane) ? r_wdata[7:0] : ram_rdata[k*8 +: 8];
        end
        sel = {r_pa[15:4], 4'h0};
    end

    always_comb begin
        n_flash  = r_flash;
        consumed = 1'b0;
        if ((r_state == ST_RESP) && (r_op == OP_WR_WORD) && !r_read_only &&
            (r_flash_code != '0)) begin
            if ((r_pa == '0) && (r_wdata == FL_RESET_WORD)) begin
                consumed = 1'b1;
                n_flash  = (r_flash == FL_IDLE) ? FL_STEP1 : FL_IDLE;
            end else begin
                case (r_flash)
                    FL_STEP1: begin
                        if ((sel == FL_ADDR_A) && (r_wdata == FL_UNLOCK1_WORD)) begin
                            consumed = 1'b1;
                            n_flash  = FL_STEP2;
                        end else begin
                            n_flash  = FL_FAILED;
                        end
                    end
                    FL_STEP2: begin
                        if ((sel == FL_ADDR_B) && (r_wdata == FL_UNLOCK2_WORD)) begin
                            consumed = 1'b1;
                            n_flash  = FL_STEP3;
                        end else begin
                            n_flash  = FL_FAILED;
                        end
                    end
                    FL_STEP3: begin
                        if ((sel == FL_ADDR_A) && (r_wdata == FL_AUTOSEL_WORD)) begin
                            consumed = 1'b1;
                            n_flash  = FL_UNLOCKED;
                        end else begin
                            n_flash  = FL_FAILED;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_idx;
        ram_wdata = '0;
        n_data    = '0;
        n_blocked = 1'b0;
        if (r_state == ST_CLEAR) begin
            ram_we   = 1'b1;
            ram_addr = r_clr;
        end
        case (r_op)
            OP_RD_WORD: begin
                n_data = ((r_flash == FL_UNLOCKED) && (r_pa == FL_ID_ADDR)) ?
                         r_flash_code : ram_rdata;
            end
            OP_WR_WORD: begin
                n_data    = r_wdata;
                n_blocked = r_read_only;
                if ((r_state == ST_RESP) && !r_read_only && !consumed) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_wdata;
                end
            end
            OP_RD_BYTE: begin
                n_data = {24'h0, rd_byte};
            end
            OP_WR_BYTE: begin
                n_data    = {24'h0, r_wdata[7:0]};
                n_blocked = r_read_only;
                if ((r_state == ST_RESP) && !r_read_only) begin
                    ram_we    = 1'b1;
                    ram_wdata = merged;
                end
            end
            default: ;
        endcase
    end

    mwfid_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_flash <= FL_IDLE;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flash <= n_flash;
            r_valid <= (r_state == ST_RESP);
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_addr     <= '0;
            r_region_length <= REGION_LEN_RESET;
            r_alias_base    <= '0;
            r_alias_phys    <= '0;
            r_alias_length  <= '0;
            r_flash_code    <= '0;
            r_read_only     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BASE_ADDR:     r_base_addr     <= i_cfg_data;
                REG_REGION_LENGTH: r_region_length <= i_cfg_data[LEN_W-1:0];
                REG_ALIAS_BASE:    r_alias_base    <= i_cfg_data;
                REG_ALIAS_PHYS:    r_alias_phys    <= i_cfg_data[PHYS_W-1:0];
                REG_ALIAS_LENGTH:  r_alias_length  <= i_cfg_data[LEN_W-1:0];
                REG_FLASH_CODE:    r_flash_code    <= i_cfg_data;
                REG_READ_ONLY:     r_read_only     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && start) begin
            r_op    <= t_op'(i_op);
            r_addr  <= i_address;
            r_wdata <= i_write_data;
        end
        if ((r_state == ST_MAP) && map_direct) begin
            r_pa <= alias_hit ? alias_pa : off_main;
        end else if ((r_state == ST_REM1) && rem_done) begin
            r_pa <= ADDR_W'(rem_value);
        end
        // word index wraps by truncation to the store size
        if (r_state == ST_IDX) begin
            r_idx <= r_pa[IDX_W+1:2];
        end
        if (r_state == ST_RESP) begin
            r_data    <= n_data;
            r_blocked <= n_blocked;
        end
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_data          = r_data;
    assign o_write_blocked = r_blocked;

    // ---------------- assertions ----------------
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but block not busy");

    a_blocked_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_write_blocked) |-> !$past(ram_we))
        else $error("refused write reached the store");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (busy && !o_valid))
        else $error("activity during clearing pass");

endmodule

`default_nettype wire

// ===== hdl/mwfid_ram.sv =====
// Generic single-port synchronous RAM with registered read.
`default_nettype none

module mwfid_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/mwfid_rem.sv =====
// Iterative remainder unit, restoring, several dividend bits per cycle.
`default_nettype none

module mwfid_rem
    import mwfid_pkg::*;
#(
    parameter int DIV_W = 17
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [ADDR_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic      [DIV_W-1:0]  o_rem
);

    localparam int STEPS = ADDR_W / REM_STEP_BITS;
    localparam int CNT_W = $clog2(STEPS);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_div;
    logic [ADDR_W-1:0] r_sh;

    logic [DIV_W-1:0]  n_rem;
    logic [DIV_W-1:0]  acc;
    logic [DIV_W:0]    trial;

    always_comb begin
        acc   = r_rem;
        trial = '0;
        for (int k = 0; k < REM_STEP_BITS; k++) begin
            trial = {acc, r_sh[ADDR_W-1-k]};
            if (trial >= {1'b0, r_div}) begin
                acc = DIV_W'(trial - {1'b0, r_div});
            end else begin
                acc = trial[DIV_W-1:0];
            end
        end
        n_rem = acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_sh  <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_sh  <= r_sh << REM_STEP_BITS;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the mapped word memory with flash ID emulation: shadow model scoreboard.

module tb_top;
    import mwfid_pkg::*;

    localparam int          STORE_WORDS = 16384;
    localparam int          LIMIT       = 400000;
    localparam logic [31:0] SEL_MASK    = 32'h0000_fff0;
    localparam logic [31:0] BYTE_MASK   = 32'h0000_00ff;

    typedef struct packed {
        logic [31:0] data;
        logic        blocked;
    } t_reply;

    class flash_mem_scoreboard;
        logic [31:0] shadow_words [STORE_WORDS];
        t_flash      flash_state;
        logic [31:0] base_addr;
        logic [16:0] region_len;
        logic [31:0] alias_base;
        logic [15:0] alias_phys;
        logic [16:0] alias_len;
        logic [31:0] flash_code;
        logic        read_only;
        t_reply      pending_replies[$];
        int          errors;
        int          commands;
        int          checked;
        int          unlocks;
        int          id_hits;
        int          refused;

        function new();
            foreach (shadow_words[k]) shadow_words[k] = '0;
            flash_state = FL_IDLE;
            base_addr   = '0;
            region_len  = REGION_LEN_RESET;
            alias_base  = '0;
            alias_phys  = '0;
            alias_len   = '0;
            flash_code  = '0;
            read_only   = 1'b0;
        endfunction

        function void set_reg(t_reg idx, logic [31:0] v);
            case (idx)
                REG_BASE_ADDR:     base_addr  = v;
                REG_REGION_LENGTH: region_len = v[16:0];
                REG_ALIAS_BASE:    alias_base = v;
                REG_ALIAS_PHYS:    alias_phys = v[15:0];
                REG_ALIAS_LENGTH:  alias_len  = v[16:0];
                REG_FLASH_CODE:    flash_code = v;
                REG_READ_ONLY:     read_only  = v[0];
                default: ;
            endcase
        endfunction

        function logic [31:0] translate(logic [31:0] va);
            logic [31:0] off;
            off = va - alias_base;
            if (alias_len != 0 && off < alias_len)
                return alias_phys + off;
            off = va - base_addr;
            if (region_len != 0)
                off = off % region_len;
            return off;
        endfunction

        function int unsigned slot(logic [31:0] pa);
            return (pa >> 2) % STORE_WORDS;
        endfunction

        // best-effort inverse map, used only to aim stimulus at a physical address
        function logic [31:0] to_virtual(logic [31:0] pa);
            logic [31:0] va;
            va = base_addr + ((region_len != 0) ? pa % region_len : pa);
            if (translate(va) == pa)
                return va;
            if (alias_len != 0 && pa >= alias_phys && pa - alias_phys < alias_len)
                return alias_base + (pa - alias_phys);
            return va;
        endfunction

        // returns 1 when the write is swallowed as a command
        function bit flash_cmd(logic [31:0] pa, logic [31:0] v);
            logic [31:0] sel;
            bit          ok;
            sel = pa & SEL_MASK;
            ok  = 1'b0;
            if (pa == 0 && v == FL_RESET_WORD) begin
                flash_state = (flash_state == FL_IDLE) ? FL_STEP1 : FL_IDLE;
                return 1'b1;
            end
            case (flash_state)
                FL_STEP1: ok = (sel == FL_ADDR_A && v == FL_UNLOCK1_WORD);
                FL_STEP2: ok = (sel == FL_ADDR_B && v == FL_UNLOCK2_WORD);
                FL_STEP3: ok = (sel == FL_ADDR_A && v == FL_AUTOSEL_WORD);
                default:  return 1'b0;
            endcase
            if (!ok) begin
                flash_state = FL_FAILED;
                return 1'b0;
            end
            case (flash_state)
                FL_STEP1: flash_state = FL_STEP2;
                FL_STEP2: flash_state = FL_STEP3;
                default: begin
                    flash_state = FL_UNLOCKED;
                    unlocks++;
                end
            endcase
            return 1'b1;
        endfunction

        function void note_access(t_op op, logic [31:0] addr, logic [31:0] wd);
            t_reply      r;
            logic [31:0] pa;
            logic [31:0] w;
            int unsigned idx;
            int unsigned sh;
            bit          taken;
            r.data    = '0;
            r.blocked = 1'b0;
            commands++;
            case (op)
                OP_RD_WORD: begin
                    pa     = translate(addr);
                    r.data = shadow_words[slot(pa)];
                    if (flash_state == FL_UNLOCKED && pa == FL_ID_ADDR) begin
                        r.data = flash_code;
                        id_hits++;
                    end
                end
                OP_WR_WORD: begin
                    r.data = wd;
                    if (read_only) begin
                        r.blocked = 1'b1;
                        refused++;
                    end else begin
                        pa    = translate(addr);
                        taken = 1'b0;
                        if (flash_code != 0)
                            taken = flash_cmd(pa, wd);
                        if (!taken)
                            shadow_words[slot(pa)] = wd;
                    end
                end
                default: begin
                    // byte 0 is the most significant lane
                    sh  = (3 - int'(addr[1:0])) * 8;
                    idx = slot(translate({addr[31:2], 2'b00}));
                    if (op == OP_RD_BYTE) begin
                        r.data = (shadow_words[idx] >> sh) & BYTE_MASK;
                    end else begin
                        r.data = wd & BYTE_MASK;
                        if (read_only) begin
                            r.blocked = 1'b1;
                            refused++;
                        end else begin
                            w = shadow_words[idx] & ~(BYTE_MASK << sh);
                            shadow_words[idx] = w | ((wd & BYTE_MASK) << sh);
                        end
                    end
                end
            endcase
            pending_replies.push_back(r);
        endfunction

        task report_mismatch(string msg);
            if (errors < 200)
                $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_reply(logic [31:0] data, logic blocked);
            t_reply e;
            if (pending_replies.size() == 0) begin
                report_mismatch($sformatf("word with nothing pending, data %h", data));
                return;
            end
            e = pending_replies.pop_front();
            checked++;
            if (data !== e.data)
                report_mismatch($sformatf("data %h, want %h", data, e.data));
            if (blocked !== e.blocked)
                report_mismatch($sformatf("write_blocked %b, want %b", blocked, e.blocked));
        endtask

        function int pending();
            return pending_replies.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_op;
    logic [31:0] i_address;
    logic [31:0] i_write_data;
    logic        o_valid;
    logic [31:0] o_data;
    logic        o_write_blocked;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    flash_mem_scoreboard sb;
    int                  sent;
    int                  settings;
    int                  cycles;
    bit                  idle_on;

    mapped_word_memory_flash_id_top #(
        .STORE_WORDS(STORE_WORDS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .o_valid        (o_valid),
        .o_data         (o_data),
        .o_write_blocked(o_write_blocked),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // sample pre-edge values; driver updates land in the NBA region
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.set_reg(t_reg'(i_cfg_index), i_cfg_data);
            if (start && busy === 1'b0)
                sb.note_access(t_op'(i_op), i_address, i_write_data);
            if (o_valid === 1'b1)
                sb.check_reply(o_data, o_write_blocked);
        end
    end

    task automatic issue(t_op op, logic [31:0] addr, logic [31:0] wd);
        start        <= 1'b1;
        i_op         <= op;
        i_address    <= addr;
        i_write_data <= wd;
        do @(posedge i_clk); while (busy);
        sent++;
        if (idle_on && $urandom_range(0, 99) < 25) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0 || busy);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [31:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
    endtask

    task automatic load_map(logic [31:0] base, logic [31:0] len, logic [31:0] abase,
                            logic [31:0] aphys, logic [31:0] alen, logic [31:0] code,
                            logic [31:0] ro);
        settle();
        write_reg(REG_BASE_ADDR, base);
        write_reg(REG_REGION_LENGTH, len);
        write_reg(REG_ALIAS_BASE, abase);
        write_reg(REG_ALIAS_PHYS, aphys);
        write_reg(REG_ALIAS_LENGTH, alen);
        write_reg(REG_FLASH_CODE, code);
        write_reg(REG_READ_ONLY, ro);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic random_map(logic [31:0] ro);
        load_map($urandom, $urandom_range(4, 65536), $urandom, $urandom_range(0, 65535),
                 ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 65536),
                 ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom, ro);
    endtask

    // reset command (at times twice), three unlock writes (one maybe broken), then ID reads
    task automatic unlock_burst();
        logic [31:0] pattern [3];
        logic [31:0] site [3];
        logic [31:0] pa;
        logic [31:0] d;
        int          bad;
        pattern = '{FL_UNLOCK1_WORD, FL_UNLOCK2_WORD, FL_AUTOSEL_WORD};
        site    = '{32'(FL_ADDR_A), 32'(FL_ADDR_B), 32'(FL_ADDR_A)};
        bad     = ($urandom_range(0, 99) < 30) ? $urandom_range(0, 2) : 3;
        issue(OP_WR_WORD, sb.to_virtual(0), FL_RESET_WORD);
        if ($urandom_range(0, 9) == 0)
            issue(OP_WR_WORD, sb.to_virtual(0), FL_RESET_WORD);
        for (int k = 0; k < 3; k++) begin
            pa = site[k] | $urandom_range(0, 15);
            d  = pattern[k];
            if (k == bad) begin
                if ($urandom_range(0, 1))
                    d = d ^ (32'd1 << $urandom_range(0, 31));
                else
                    pa = pa ^ (32'h10 << $urandom_range(0, 11));
            end
            issue(OP_WR_WORD, sb.to_virtual(pa), d);
        end
        issue(OP_RD_WORD, sb.to_virtual(FL_ID_ADDR), $urandom);
        case ($urandom_range(0, 3))
            0: issue(OP_RD_WORD, sb.to_virtual(FL_ID_ADDR + $urandom_range(1, 3)), $urandom);
            1: issue(OP_RD_BYTE, sb.to_virtual(FL_ID_ADDR + $urandom_range(0, 3)), $urandom);
            2: begin
                issue(OP_WR_WORD, sb.to_virtual($urandom_range(8, 255)), $urandom);
                issue(OP_RD_WORD, sb.to_virtual(FL_ID_ADDR), $urandom);
            end
            default: ;
        endcase
    endtask

    task automatic mixed_access();
        t_op         op;
        logic [31:0] addr;
        logic [31:0] wd;
        op = t_op'($urandom_range(0, 3));
        wd = $urandom;
        case ($urandom_range(0, 5))
            0, 1, 2: addr = sb.to_virtual($urandom_range(0, 255));
            3:       addr = sb.alias_base + $urandom_range(0, 300) - 8;
            4:       addr = sb.base_addr - $urandom_range(1, 16);
            default: addr = $urandom;
        endcase
        case ($urandom_range(0, 15))
            0: wd = FL_RESET_WORD;
            1: wd = FL_UNLOCK1_WORD;
            2: wd = FL_UNLOCK2_WORD;
            3: wd = FL_AUTOSEL_WORD;
            default: ;
        endcase
        issue(op, addr, wd);
    endtask

    task automatic run_phase(int n);
        int target;
        target = sent + n;
        while (sent < target) begin
            if ($urandom_range(0, 99) < 30)
                unlock_burst();
            else
                mixed_access();
        end
    endtask

    initial begin
        sb           = new();
        sent         = 0;
        settings     = 0;
        cycles       = 0;
        idle_on      = 1'b1;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_op         <= OP_RD_WORD;
        i_address    <= '0;
        i_write_data <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= REG_BASE_ADDR;
        i_cfg_data   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        // store clear runs with busy high
        while (busy !== 1'b0) @(posedge i_clk);

        // alias window wraps past the top of the address space
        load_map(32'h1000_0000, 32'd65536, 32'hffff_f000, 32'h0000_fff0, 32'h0000_2000,
                 32'hdead_beef, 32'd0);
        issue(OP_WR_WORD, 32'h1000_0000, 32'hffff_ffff);
        issue(OP_RD_WORD, 32'h1000_0000, 32'h0);
        issue(OP_WR_BYTE, 32'h1000_0011, 32'h0000_00a5);
        issue(OP_WR_BYTE, 32'h1000_0013, 32'hffff_ff3c);
        issue(OP_RD_WORD, 32'h1000_0010, 32'h0);
        issue(OP_RD_BYTE, 32'h1000_0011, 32'hffff_ffff);
        issue(OP_WR_WORD, 32'h0fff_fffe, 32'h0123_4567);
        issue(OP_RD_BYTE, 32'h1000_fffc, 32'h0);
        issue(OP_WR_WORD, 32'hffff_fffc, 32'h8000_0001);
        issue(OP_RD_WORD, 32'hffff_fffd, 32'h0);
        // clean unlock, ID read, then the neighbors of the ID address
        issue(OP_WR_WORD, 32'h1000_0000, FL_RESET_WORD);
        issue(OP_WR_WORD, 32'h1000_555c, FL_UNLOCK1_WORD);
        issue(OP_WR_WORD, 32'h1000_aaa8, FL_UNLOCK2_WORD);
        issue(OP_WR_WORD, 32'h1000_5550, FL_AUTOSEL_WORD);
        issue(OP_RD_WORD, 32'h1000_0004, 32'h0);
        issue(OP_RD_WORD, 32'h1000_0006, 32'h0);
        issue(OP_RD_BYTE, 32'h1000_0004, 32'h0);
        // reset leaves unlocked, then a wrong step fails and is stored
        issue(OP_WR_WORD, 32'h1000_0000, FL_RESET_WORD);
        issue(OP_WR_WORD, 32'h1000_0000, FL_RESET_WORD);
        issue(OP_WR_WORD, 32'h1000_5550, FL_UNLOCK2_WORD);
        issue(OP_RD_WORD, 32'h1000_5550, 32'h0);
        issue(OP_RD_WORD, 32'h1000_0004, 32'h0);
        // read-only with no region modulo
        load_map(32'hffff_ffff, 32'd0, 32'h0, 32'h0, 32'h0, 32'hdead_beef, 32'd1);
        issue(OP_WR_WORD, 32'h0000_0003, 32'h5a5a_5a5a);
        issue(OP_WR_BYTE, 32'hffff_ffff, 32'h0000_00ff);
        issue(OP_RD_WORD, 32'h0000_0003, 32'h0);

        load_map(32'h0, 32'd65536, 32'h0, 32'h0, 32'h0, 32'h1234_5678, 32'd0);
        run_phase(190);
        load_map(32'hffff_ffff, 32'd4, 32'h8000_0000, 32'd65535, 32'd65536, 32'hffff_ffff,
                 32'd0);
        run_phase(190);
        idle_on = 1'b0;
        random_map(32'd0);
        run_phase(190);
        idle_on = 1'b1;
        load_map(32'hffff_0000, 32'd0, 32'hffff_fff0, 32'h0, 32'd32, 32'h0, 32'd0);
        run_phase(190);
        random_map(32'd1);
        run_phase(190);
        repeat (3) begin
            random_map(32'd0);
            run_phase(190);
        end

        settle();
        repeat (20) @(posedge i_clk);
        $display("%0d commands over %0d register settings, %0d words checked, %0d refused",
                 sb.commands, settings, sb.checked, sb.refused);
        $display("flash unlocked %0d times, ID word read back %0d times",
                 sb.unlocks, sb.id_hits);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mwfid_pkg.sv
hdl/mwfid_ram.sv
hdl/mwfid_rem.sv
hdl/mapped_word_memory_flash_id_top.sv
sim/tb_top.sv
